// ----- design/pls_pkg.sv -----
package pls_pkg;

  // Operation codes carried in the opcode field.
  typedef enum logic [1:0] {
    OP_INSERT   = 2'd0,
    OP_DELETE   = 2'd1,
    OP_RETRIEVE = 2'd2,
    OP_CLEAR    = 2'd3
  } opcode_e;

  // Status codes returned with every result.
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  localparam int unsigned ValueW = 16;
  localparam int unsigned TagW   = 8;
  localparam int unsigned PosW   = 7;
  localparam int unsigned CountW = 7;

  typedef struct packed {
    logic [TagW-1:0]   tag;
    logic [ValueW-1:0] value;
  } entry_t;

  // Shift commands broadcast to every cell of the chain.
  typedef struct packed {
    logic ins;
    logic del;
  } ctrl_t;

endpackage

// ----- design/positional_list_store.sv -----
// Ordered list of up to CAPACITY value/tag entries kept in a row of cells, one entry per
// cell. Every operation (insert, delete, retrieve, clear) leaves its single result in the
// output register on the edge that takes it; a new operation is taken in every cycle as
// long as the result side keeps up, so the sustained rate is one operation per cycle. The
// cycle that takes an operation holds the broadcast position compare in each cell and the
// OR of all cells onto the read bus. There is no clearing pass after reset.
module positional_list_store #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // From bit 0: opcode[1:0], position[8:2], entry_value[24:9], entry_tag[32:25], zero pad.
  input  logic [39:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // From bit 0: status[1:0], out_value[17:2], out_tag[25:18], entry_count[32:26],
  // is_empty[33], zero pad.
  output logic [39:0] m_axis_tdata_o
);

  localparam int unsigned CW  = $clog2(CAPACITY + 1);
  localparam int unsigned XB  = (CW > pls_pkg::PosW) ? CW : pls_pkg::PosW;
  localparam int unsigned XW  = XB + 1;

  pls_pkg::opcode_e          opcode;
  logic [pls_pkg::PosW-1:0]  position;
  pls_pkg::entry_t           new_entry;
  logic [XW-1:0]             pos_x;
  logic [XW-1:0]             count_x;

  logic                      accept;
  logic                      full;
  logic                      pos_ok;
  logic                      pos_ok_ins;
  pls_pkg::ctrl_t            ctrl;
  pls_pkg::entry_t           rd;

  logic [CW-1:0]             count_q, count_d;
  logic                      out_valid_q, out_valid_d;
  pls_pkg::status_e          status_q, status_d;
  pls_pkg::entry_t           res_q, res_d;
  logic [pls_pkg::CountW-1:0] res_count_q, res_count_d;
  logic                      res_empty_q, res_empty_d;

  pls_pkg::entry_t           cell_data [CAPACITY];
  pls_pkg::entry_t           cell_rd   [CAPACITY];

  assign opcode          = pls_pkg::opcode_e'(s_axis_tdata_i[1:0]);
  assign position        = s_axis_tdata_i[8:2];
  assign new_entry.value = s_axis_tdata_i[24:9];
  assign new_entry.tag   = s_axis_tdata_i[32:25];

  assign s_axis_tready_o = !out_valid_q || m_axis_tready_i;
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  assign pos_x      = XW'(position);
  assign count_x    = XW'(count_q);
  assign full       = (count_q == CW'(CAPACITY));
  assign pos_ok     = (pos_x != '0) && (pos_x <= count_x);
  assign pos_ok_ins = (pos_x != '0) && (pos_x <= count_x + XW'(1));

  always_comb begin
    rd = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd = pls_pkg::entry_t'(rd | cell_rd[i]);
    end
  end

  always_comb begin
    ctrl        = '0;
    count_d     = count_q;
    status_d    = status_q;
    res_d       = res_q;
    res_count_d = res_count_q;
    res_empty_d = res_empty_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    if (accept) begin
      status_d = pls_pkg::ST_OK;
      res_d    = '0;
      case (opcode)
        pls_pkg::OP_INSERT: begin
          if (full) begin
            status_d = pls_pkg::ST_FULL;
          end else if (!pos_ok_ins) begin
            status_d = pls_pkg::ST_INVALID;
          end else begin
            ctrl.ins = 1'b1;
            count_d  = count_q + CW'(1);
          end
        end
        pls_pkg::OP_DELETE: begin
          if (!pos_ok) begin
            status_d = pls_pkg::ST_INVALID;
          end else begin
            ctrl.del = 1'b1;
            res_d    = rd;
            count_d  = count_q - CW'(1);
          end
        end
        pls_pkg::OP_RETRIEVE: begin
          if (count_q == '0) begin
            status_d = pls_pkg::ST_EMPTY;
          end else if (!pos_ok) begin
            status_d = pls_pkg::ST_INVALID;
          end else begin
            res_d = rd;
          end
        end
        default: begin
          count_d = '0;
        end
      endcase
      res_count_d = pls_pkg::CountW'(count_d);
      res_empty_d = (count_d == '0);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q    <= status_d;
    res_q       <= res_d;
    res_count_q <= res_count_d;
    res_empty_q <= res_empty_d;
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    pls_pkg::entry_t left;
    pls_pkg::entry_t right;
    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_data[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_data[i+1];
    end
    pls_cell #(
      .IDX (i),
      .XW  (XW)
    ) u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .pos_i   (pos_x),
      .new_i   (new_entry),
      .left_i  (left),
      .right_i (right),
      .data_o  (cell_data[i]),
      .rd_o    (cell_rd[i])
    );
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, res_empty_q, res_count_q, res_q.tag, res_q.value,
                            status_q};

endmodule

// ----- design/pls_cell.sv -----
module pls_cell #(
  parameter int unsigned IDX = 0,
  parameter int unsigned XW  = 8
) (
  input  logic             clk_i,
  input  pls_pkg::ctrl_t   ctrl_i,
  input  logic [XW-1:0]    pos_i,
  input  pls_pkg::entry_t  new_i,
  input  pls_pkg::entry_t  left_i,
  input  pls_pkg::entry_t  right_i,
  output pls_pkg::entry_t  data_o,
  output pls_pkg::entry_t  rd_o
);

  // One-based position held by this cell.
  localparam logic [XW-1:0] MyPos = XW'(IDX + 1);

  pls_pkg::entry_t entry_q, entry_d;
  logic            hit;
  logic            above;

  assign hit   = (pos_i == MyPos);
  assign above = (pos_i < MyPos);

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (hit) begin
        entry_d = new_i;
      end else if (above) begin
        entry_d = left_i;
      end
    end else if (ctrl_i.del) begin
      // Cells at and above the deleted position take their right neighbor.
      if (hit || above) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign data_o = entry_q;
  assign rd_o   = hit ? entry_q : '0;

endmodule

// ----- design/pls_checker.sv -----
module pls_checker #(
  parameter int unsigned CAPACITY = 64
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic [39:0] s_axis_tdata_i,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [39:0] m_axis_tdata_o
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid_i && s_axis_tready_o;

  // A result that is not taken stays in place.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Every accepted operation gives a result on the next edge.
  a_one_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> m_axis_tvalid_o)
    else $error("accepted operation produced no result");

  // The empty flag agrees with the reported count.
  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (m_axis_tdata_o[33] == (m_axis_tdata_o[32:26] == 7'd0)))
    else $error("empty flag disagrees with count");

  // A failed operation returns no data.
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tdata_o[1:0] != 2'd0) |-> (m_axis_tdata_o[25:2] == 24'd0))
    else $error("failed operation returned data");

  // The count never exceeds the capacity.
  a_count_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (int'(m_axis_tdata_o[32:26]) <= int'(CAPACITY)))
    else $error("count above capacity");

endmodule

bind positional_list_store pls_checker #(
  .CAPACITY (CAPACITY)
) u_pls_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .s_axis_tdata_i  (s_axis_tdata_i),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int ListCap = 64;
  localparam int BlockLen = 50;
  localparam int NumBlocks = 13;

  // One operation as it travels in s_axis_tdata; the last member sits in the lowest bits.
  typedef struct packed {
    logic [pls_pkg::TagW-1:0]   tag;
    logic [pls_pkg::ValueW-1:0] value;
    logic [pls_pkg::PosW-1:0]   pos;
    pls_pkg::opcode_e           op;
  } list_cmd_t;

  // One result as it travels in m_axis_tdata.
  typedef struct packed {
    logic                       is_empty;
    logic [pls_pkg::CountW-1:0] count;
    logic [pls_pkg::TagW-1:0]   tag;
    logic [pls_pkg::ValueW-1:0] value;
    pls_pkg::status_e           status;
  } list_result_t;

  typedef enum int {
    GEN_GROW,
    GEN_SHRINK,
    GEN_MIXED
  } gen_mode_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [39:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  positional_list_store #(
    .CAPACITY(ListCap)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Predicted list contents, kept in step with accepted operations.
  logic [pls_pkg::ValueW-1:0] list_value [ListCap];
  logic [pls_pkg::TagW-1:0]   list_tag   [ListCap];
  int                         list_len = 0;

  list_cmd_t    pending_cmds[$];
  list_result_t expected_results[$];
  int           cmds_queued = 0;
  int           cmds_accepted = 0;
  int           results_seen = 0;
  int           mismatch_count = 0;
  int           gen_len = 0;

  int op_hits[4] = '{default: 0};
  int full_rejects = 0;
  int bad_positions = 0;
  int empty_reads = 0;
  int peak_len = 0;

  function automatic list_result_t apply_list_op(list_cmd_t cmd);
    list_result_t res;
    int           idx;
    res = '0;
    res.status = pls_pkg::ST_OK;
    op_hits[cmd.op]++;
    case (cmd.op)
      pls_pkg::OP_INSERT: begin
        if (list_len >= ListCap) begin
          res.status = pls_pkg::ST_FULL;
        end else if (cmd.pos < 1 || cmd.pos > list_len + 1) begin
          res.status = pls_pkg::ST_INVALID;
        end else begin
          for (idx = list_len; idx > cmd.pos - 1; idx--) begin
            list_value[idx] = list_value[idx-1];
            list_tag[idx]   = list_tag[idx-1];
          end
          list_value[cmd.pos-1] = cmd.value;
          list_tag[cmd.pos-1]   = cmd.tag;
          list_len++;
        end
      end
      pls_pkg::OP_DELETE: begin
        if (cmd.pos < 1 || cmd.pos > list_len) begin
          res.status = pls_pkg::ST_INVALID;
        end else begin
          res.value = list_value[cmd.pos-1];
          res.tag   = list_tag[cmd.pos-1];
          for (idx = cmd.pos - 1; idx + 1 < list_len; idx++) begin
            list_value[idx] = list_value[idx+1];
            list_tag[idx]   = list_tag[idx+1];
          end
          list_len--;
        end
      end
      pls_pkg::OP_RETRIEVE: begin
        if (list_len == 0) begin
          res.status = pls_pkg::ST_EMPTY;
        end else if (cmd.pos < 1 || cmd.pos > list_len) begin
          res.status = pls_pkg::ST_INVALID;
        end else begin
          res.value = list_value[cmd.pos-1];
          res.tag   = list_tag[cmd.pos-1];
        end
      end
      default: begin
        list_len = 0;
      end
    endcase
    res.count    = pls_pkg::CountW'(list_len);
    res.is_empty = (list_len == 0);
    if (res.status == pls_pkg::ST_FULL) full_rejects++;
    if (res.status == pls_pkg::ST_INVALID) bad_positions++;
    if (res.status == pls_pkg::ST_EMPTY) empty_reads++;
    if (list_len > peak_len) peak_len = list_len;
    return res;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] want, logic [15:0] seen);
    $display("MISMATCH %s at result %0d: expected %0h, got %0h", what, results_seen, want,
             seen);
    mismatch_count++;
  endtask

  // Pause length for one item: random stretches with and without idle cycles.
  function automatic int draw_pause(inout int left, inout bit idle_on);
    if (left == 0) begin
      left    = $urandom_range(20, 80);
      idle_on = ($urandom_range(0, 2) != 0);
    end
    left--;
    return idle_on ? $urandom_range(0, 9) : 0;
  endfunction

  // Queues one operation and tracks the list length that it leaves behind.
  task automatic queue_cmd(pls_pkg::opcode_e op, int pos, logic [15:0] v, logic [7:0] t);
    list_cmd_t cmd;
    cmd.op    = op;
    cmd.pos   = pos[pls_pkg::PosW-1:0];
    cmd.value = v;
    cmd.tag   = t;
    pending_cmds.push_back(cmd);
    cmds_queued++;
    case (op)
      pls_pkg::OP_INSERT:
        if (gen_len < ListCap && pos >= 1 && pos <= gen_len + 1) gen_len++;
      pls_pkg::OP_DELETE:
        if (pos >= 1 && pos <= gen_len) gen_len--;
      pls_pkg::OP_CLEAR:
        gen_len = 0;
      default: ;
    endcase
  endtask

  // Mostly positions that hit an entry (or the slot just past the tail for insert),
  // otherwise zero, one past the limit, or anything the field can carry.
  function automatic int rand_pos(pls_pkg::opcode_e op, int len);
    int hi;
    hi = (op == pls_pkg::OP_INSERT) ? len + 1 : len;
    if (hi > ListCap) hi = ListCap;
    if (op != pls_pkg::OP_CLEAR && hi >= 1 && $urandom_range(0, 99) < 85) begin
      return $urandom_range(1, hi);
    end
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return hi + 1;
      default: return $urandom_range(0, 127);
    endcase
  endfunction

  function automatic pls_pkg::opcode_e rand_op(gen_mode_e mode);
    int r;
    int ins_w;
    int del_w;
    r = $urandom_range(0, 99);
    case (mode)
      GEN_GROW: begin
        ins_w = 75;
        del_w = 8;
      end
      GEN_SHRINK: begin
        ins_w = 10;
        del_w = 70;
      end
      default: begin
        ins_w = 40;
        del_w = 35;
      end
    endcase
    if (r < ins_w) return pls_pkg::OP_INSERT;
    if (r < ins_w + del_w) return pls_pkg::OP_DELETE;
    if (r < 98) return pls_pkg::OP_RETRIEVE;
    return pls_pkg::OP_CLEAR;
  endfunction

  // Stimulus and end of run.
  initial begin
    gen_mode_e        mode;
    pls_pkg::opcode_e op;
    // Directed: empty-list cases, bad positions, head, tail and middle insert, head and tail delete.
    queue_cmd(pls_pkg::OP_CLEAR, 0, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_RETRIEVE, 1, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_DELETE, 1, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_DELETE, 0, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_INSERT, 0, 16'h1234, 8'h56);
    queue_cmd(pls_pkg::OP_INSERT, 2, 16'h1234, 8'h56);
    queue_cmd(pls_pkg::OP_INSERT, 1, 16'hFFFF, 8'hFF);
    queue_cmd(pls_pkg::OP_INSERT, 1, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_INSERT, 3, 16'hA5C3, 8'h3C);
    queue_cmd(pls_pkg::OP_INSERT, 2, 16'h5A3C, 8'hC3);
    queue_cmd(pls_pkg::OP_RETRIEVE, 1, 16'hFFFF, 8'hFF);
    queue_cmd(pls_pkg::OP_RETRIEVE, 2, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_RETRIEVE, 3, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_RETRIEVE, 4, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_RETRIEVE, 0, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_RETRIEVE, 5, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_RETRIEVE, 127, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_INSERT, 127, 16'hFFFF, 8'hFF);
    queue_cmd(pls_pkg::OP_DELETE, 4, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_DELETE, 1, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_DELETE, 3, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_DELETE, 2, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_RETRIEVE, 1, 16'h0000, 8'h00);
    queue_cmd(pls_pkg::OP_CLEAR, 127, 16'hFFFF, 8'hFF);
    queue_cmd(pls_pkg::OP_RETRIEVE, 1, 16'h0000, 8'h00);

    // Random blocks: two growth blocks in a row push the list toward the full case.
    for (int b = 0; b < NumBlocks; b++) begin
      case (b % 6)
        0, 1:    mode = GEN_GROW;
        3, 4:    mode = GEN_SHRINK;
        default: mode = GEN_MIXED;
      endcase
      for (int k = 0; k < BlockLen; k++) begin
        op = rand_op(mode);
        queue_cmd(op, rand_pos(op, gen_len), 16'($urandom), 8'($urandom));
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (cmds_accepted != cmds_queued || expected_results.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);

    $display("Covered %0d operations: %0d insert, %0d delete, %0d retrieve, %0d clear.",
             cmds_accepted, op_hits[pls_pkg::OP_INSERT], op_hits[pls_pkg::OP_DELETE],
             op_hits[pls_pkg::OP_RETRIEVE], op_hits[pls_pkg::OP_CLEAR]);
    $display("Full-list inserts %0d, bad positions %0d, empty reads %0d, peak length %0d.",
             full_rejects, bad_positions, empty_reads, peak_len);
    if (mismatch_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

  initial begin
    #400_000;
    $display("tb_top failed");
    $finish;
  end

  // Driver: presents queued operations, predicting each one as its transfer completes.
  list_cmd_t cur_cmd;
  int        feed_wait = 0;
  int        feed_left = 0;
  bit        feed_idle = 1'b0;
  int        feed_gap;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_tvalid  <= 1'b0;
      feed_wait <= 0;
    end else begin
      if (s_tvalid && s_tready) begin
        expected_results.push_back(apply_list_op(cur_cmd));
        cmds_accepted++;
        feed_gap = draw_pause(feed_left, feed_idle);
      end else begin
        feed_gap = feed_wait;
      end
      if ((s_tvalid && s_tready) || !s_tvalid) begin
        if (feed_gap == 0 && pending_cmds.size() > 0) begin
          cur_cmd = pending_cmds.pop_front();
          s_tdata   <= {7'd0, cur_cmd};
          s_tvalid  <= 1'b1;
          feed_wait <= 0;
        end else begin
          s_tvalid  <= 1'b0;
          feed_wait <= (feed_gap > 0) ? feed_gap - 1 : 0;
        end
      end
    end
  end

  // Monitor: checks each result transfer against the oldest prediction.
  list_result_t got;
  list_result_t want;
  int           sink_wait = 0;
  int           sink_left = 0;
  bit           sink_idle = 1'b0;
  int           sink_gap;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_tready  <= 1'b0;
      sink_wait <= 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = list_result_t'(m_tdata[33:0]);
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", 16'h0, 16'(got.status));
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            report_mismatch("status", 16'(want.status), 16'(got.status));
          if (got.value !== want.value)
            report_mismatch("out_value", want.value, got.value);
          if (got.tag !== want.tag)
            report_mismatch("out_tag", 16'(want.tag), 16'(got.tag));
          if (got.count !== want.count)
            report_mismatch("entry_count", 16'(want.count), 16'(got.count));
          if (got.is_empty !== want.is_empty)
            report_mismatch("is_empty", 16'(want.is_empty), 16'(got.is_empty));
        end
        results_seen++;
        sink_gap = draw_pause(sink_left, sink_idle);
      end else begin
        sink_gap = sink_wait;
      end
      if ((m_tvalid && m_tready) || !m_tready) begin
        if (sink_gap == 0) begin
          m_tready  <= 1'b1;
          sink_wait <= 0;
        end else begin
          m_tready  <= 1'b0;
          sink_wait <= sink_gap - 1;
        end
      end
    end
  end

endmodule
